/* rtl/core/mfcs_pkg.sv */
// Shared types and constants for the midpoint filled-circle span generator.
`timescale 1ns / 1ps

package mfcs_pkg;

    // Fixed field widths
    localparam int RAD_W      = 5;   // circle_radius
    localparam int DIM_W      = 13;  // image_width, image_height, span_start, span_end
    localparam int ROW_W      = 14;  // span_row (signed)
    localparam int STEP_W     = 10;  // decision variable and its increments
    localparam int OUT_TDATA_W = 40; // span_row + span_start + span_end, byte aligned

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // One clipped span
    typedef struct packed {
        logic                    visible;
        logic        [DIM_W-1:0] span_end;
        logic        [DIM_W-1:0] span_start;
        logic signed [ROW_W-1:0] row;
    } span_t;

endpackage

/* rtl/core/mfcs_span_unit.sv */
// Shared span unit: row offset, start/end clipping and visibility for one span.
`timescale 1ns / 1ps

module mfcs_span_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]      center_x,
    input  logic [COORD_BITS-1:0]      center_y,
    input  logic [mfcs_pkg::RAD_W-1:0] half,
    input  logic [mfcs_pkg::RAD_W-1:0] row_off,
    input  logic                       row_neg,
    input  logic [mfcs_pkg::DIM_W-1:0] image_width,
    input  logic [mfcs_pkg::DIM_W-1:0] image_height,
    output mfcs_pkg::span_t            span
);
    import mfcs_pkg::*;

    // Compare width wide enough for coordinates and image dimensions
    localparam int CW = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;

    logic [COORD_BITS-1:0]        half_ext;
    logic [COORD_BITS-1:0]        off_ext;
    logic [COORD_BITS-1:0]        start_c;
    logic [COORD_BITS:0]          end_raw;
    logic [CW-1:0]                end_cw;
    logic [CW-1:0]                width_cw;
    logic [CW-1:0]                start_cw;
    logic [CW-1:0]                end_clip_cw;
    logic signed [COORD_BITS+1:0] row_full;
    logic [CW-1:0]                row_cw;
    logic                         row_ok;

    assign half_ext = COORD_BITS'(half);
    assign off_ext  = COORD_BITS'(row_off);

    // Start clamps at zero
    assign start_c  = (half_ext > center_x) ? '0 : center_x - half_ext;
    assign start_cw = CW'(start_c);

    // End clamps at the image width
    assign end_raw     = {1'b0, center_x} + {1'b0, half_ext};
    assign end_cw      = CW'(end_raw);
    assign width_cw    = CW'(image_width);
    assign end_clip_cw = (end_cw > width_cw) ? width_cw : end_cw;

    // Row above or below the centre
    assign row_full = row_neg ? $signed({2'b00, center_y}) - $signed({2'b00, off_ext})
                              : $signed({2'b00, center_y}) + $signed({2'b00, off_ext});
    assign row_cw   = CW'(row_full[COORD_BITS:0]);
    assign row_ok   = !row_full[COORD_BITS+1] && (row_cw < CW'(image_height));

    assign span.row        = ROW_W'(row_full);
    assign span.span_start = DIM_W'(start_c);
    assign span.span_end   = DIM_W'(end_clip_cw);
    assign span.visible    = row_ok && (start_cw < end_clip_cw);

endmodule

/* rtl/core/mfcs_stepper.sv */
// Midpoint circle stepper: decision variable and x/y walk for one circle.
`timescale 1ns / 1ps

module mfcs_stepper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       init,
    input  logic                       step,
    input  logic [mfcs_pkg::RAD_W-1:0] radius,
    output logic [mfcs_pkg::RAD_W-1:0] x,
    output logic [mfcs_pkg::RAD_W-1:0] y,
    output logic                       more
);
    import mfcs_pkg::*;

    logic signed [STEP_W-1:0] f_reg, f_next;
    logic signed [STEP_W-1:0] ddx_reg, ddx_next;
    logic signed [STEP_W-1:0] ddy_reg, ddy_next;
    logic [RAD_W-1:0]         x_reg, x_next;
    logic [RAD_W-1:0]         y_reg, y_next;
    logic signed [STEP_W-1:0] r_ext;
    logic signed [STEP_W-1:0] ddy_s;
    logic signed [STEP_W-1:0] f_s;
    logic                     f_pos;

    assign r_ext = $signed(STEP_W'(radius));
    assign f_pos = !f_reg[STEP_W-1];

    // Optional y step, then the x step
    assign ddy_s = f_pos ? ddy_reg + STEP_W'(2) : ddy_reg;
    assign f_s   = f_pos ? f_reg + ddy_s : f_reg;

    always_comb
    begin
        f_next   = f_reg;
        ddx_next = ddx_reg;
        ddy_next = ddy_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (init)
        begin
            f_next   = STEP_W'(1) - r_ext;
            ddx_next = STEP_W'(1);
            ddy_next = -(r_ext <<< 1);
            x_next   = '0;
            y_next   = radius;
        end
        else if (step)
        begin
            ddy_next = ddy_s;
            y_next   = f_pos ? y_reg - RAD_W'(1) : y_reg;
            ddx_next = ddx_reg + STEP_W'(2);
            x_next   = x_reg + RAD_W'(1);
            f_next   = f_s + ddx_reg + STEP_W'(2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg   <= '0;
            ddx_reg <= '0;
            ddy_reg <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
        end
        else
        begin
            f_reg   <= f_next;
            ddx_reg <= ddx_next;
            ddy_reg <= ddy_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign more = x_reg < y_reg;

endmodule

/* rtl/core/midpoint_filled_circle_spans.sv */
// Top level of the midpoint filled-circle span generator.
`timescale 1ns / 1ps

// Takes one circle (centre, radius) and streams its horizontal fill spans: the
// centre row first, then four spans per midpoint step (rows cy+y, cy-y, cy+x,
// cy-x), each clipped to the image set by image_width/image_height (reset
// 640 x 480). Radii above MAX_RADIUS are saturated. For a circle that takes k
// midpoint steps (k is about 0.71 * r, 14 at radius 20, giving up to 57 spans),
// one span leaves the shared clipping unit per cycle while the output accepts
// it, and each step of the decision variable takes a state of its own, in which
// no span is loaded. The input is not ready until the last span has been
// loaded into the output register.
module midpoint_filled_circle_spans #(
    parameter int MAX_RADIUS = 20,
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_wen,
    input  logic [mfcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfcs_pkg::DIM_W-1:0]       cfg_data,
    // circle requests
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // center_x, center_y, circle_radius, zero pad
    input  logic [((2*COORD_BITS+mfcs_pkg::RAD_W+7)/8)*8-1:0] s_axis_tdata,
    // spans
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // span_row, span_start, span_end
    output logic [mfcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // span_visible
    output logic                             m_axis_tuser,
    // last_span
    output logic                             m_axis_tlast
);
    import mfcs_pkg::*;

    localparam logic [RAD_W-1:0] MAX_R = RAD_W'(MAX_RADIUS);
    localparam int RAD_LSB = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_STEP
    } state_t;

    typedef enum logic [2:0] {
        PH_CENTER,
        PH_Y_POS,
        PH_Y_NEG,
        PH_X_POS,
        PH_X_NEG
    } phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic [DIM_W-1:0]      width_reg, width_next;
    logic [DIM_W-1:0]      height_reg, height_next;
    span_t                 out_span_reg, out_span_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_fire;
    logic                  load;
    logic                  span_last;
    logic [RAD_W-1:0]      in_radius;
    logic [RAD_W-1:0]      radius_sat;
    logic [RAD_W-1:0]      step_x;
    logic [RAD_W-1:0]      step_y;
    logic                  step_more;
    logic [RAD_W-1:0]      sel_half;
    logic [RAD_W-1:0]      sel_off;
    logic                  sel_neg;
    span_t                 span;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign in_radius  = s_axis_tdata[RAD_LSB +: RAD_W];
    assign radius_sat = (in_radius > MAX_R) ? MAX_R : in_radius;
    assign load       = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    // Midpoint walk
    mfcs_stepper u_stepper (
        .clk    (clk),
        .rst_n  (rst_n),
        .init   (in_fire),
        .step   (state_reg == S_STEP),
        .radius (radius_sat),
        .x      (step_x),
        .y      (step_y),
        .more   (step_more)
    );

    // Operand select for the span unit by phase
    always_comb
    begin
        sel_half  = step_y;
        sel_off   = step_x;
        sel_neg   = 1'b0;
        span_last = 1'b0;
        case (phase_reg)
            PH_CENTER:
            begin
                sel_half  = step_y;
                sel_off   = '0;
                span_last = !step_more;
            end
            PH_Y_POS:
            begin
                sel_half = step_x;
                sel_off  = step_y;
            end
            PH_Y_NEG:
            begin
                sel_half = step_x;
                sel_off  = step_y;
                sel_neg  = 1'b1;
            end
            PH_X_POS:
            begin
                sel_half = step_y;
                sel_off  = step_x;
            end
            PH_X_NEG:
            begin
                sel_half  = step_y;
                sel_off   = step_x;
                sel_neg   = 1'b1;
                span_last = !step_more;
            end
            default:
            begin
                sel_half = step_y;
            end
        endcase
    end

    mfcs_span_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .center_x     (cx_reg),
        .center_y     (cy_reg),
        .half         (sel_half),
        .row_off      (sel_off),
        .row_neg      (sel_neg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .span         (span)
    );

    // Sequencer, configuration and output register
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        out_span_next  = out_span_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (cfg_wen)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                width_next = cfg_data;
            if (cfg_index == REG_IMAGE_HEIGHT)
                height_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cx_next    = s_axis_tdata[0 +: COORD_BITS];
                    cy_next    = s_axis_tdata[COORD_BITS +: COORD_BITS];
                    phase_next = PH_CENTER;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_span_next  = span;
                    out_last_next  = span_last;
                    out_valid_next = 1'b1;
                    case (phase_reg)
                        PH_CENTER: state_next = span_last ? S_IDLE : S_STEP;
                        PH_Y_POS:  phase_next = PH_Y_NEG;
                        PH_Y_NEG:  phase_next = PH_X_POS;
                        PH_X_POS:  phase_next = PH_X_NEG;
                        PH_X_NEG:  state_next = span_last ? S_IDLE : S_STEP;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_STEP:
            begin
                phase_next = PH_Y_POS;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CENTER;
            cx_reg        <= '0;
            cy_reg        <= '0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            out_span_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_span_reg  <= out_span_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_span_reg.span_end, out_span_reg.span_start, out_span_reg.row};
    assign m_axis_tuser  = out_span_reg.visible;
    assign m_axis_tlast  = out_last_reg;

    // A new circle keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input ready right after a circle was accepted");

    // Loading the final span of a circle returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && span_last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not finish after the last span");

    // The midpoint walk never overshoots the diagonal by more than one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> ({1'b0, step_x} <= {1'b0, step_y} + 6'd1))
        else $error("midpoint walk passed the diagonal");

endmodule
